@@ design/mrar_pkg.sv @@
package mrar_pkg;

   localparam int unsigned RING_FRAMES_DEF  = 4096;
   localparam int unsigned READER_COUNT_DEF = 2;
   localparam int unsigned CHANNELS         = 2;
   localparam int unsigned SMP_W            = 14;

   typedef enum logic [1:0] {
      ACT_WRITE = 2'd0,
      ACT_READ  = 2'd1,
      ACT_DROP  = 2'd2,
      ACT_RESET = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CATCH,
      ST_ACT,
      ST_SCAN,
      ST_RESP
   } state_type;

endpackage

@@ design/multi_reader_audio_ring_unit.sv @@
// Stereo PCM16 ring with one writer and READER_COUNT readers. An action is taken when start
// is high and busy is low; its one result word appears on the rsp_ ports for exactly one
// cycle, marked by rsp_strobe, and cannot be held off by the receiver. Each action passes
// through these states from acceptance to the next possible acceptance: the catch-up (or the
// frame write, or the reader reset), the action itself (a read issues the frame memory
// access here), one scan step per reader for the level/peak/free scan, the result, and
// an idle state in which the next start is taken. RING_FRAMES must be a power of two. The
// frame memory is not cleared; only frames between a reader's position and the write
// position are ever read.
module multi_reader_audio_ring_unit
   import mrar_pkg::*;
#(
   parameter int unsigned RING_FRAMES  = RING_FRAMES_DEF,
   parameter int unsigned READER_COUNT = READER_COUNT_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  logic [1:0]              req_action,
   input  logic [2:0]              req_reader,
   input  logic signed [15:0]      req_left_sample,
   input  logic signed [15:0]      req_right_sample,
   input  logic [15:0]             req_keep_frames,
   output logic                    rsp_strobe,
   output logic                    rsp_done_res,
   output logic signed [15:0]      rsp_left_out,
   output logic signed [15:0]      rsp_right_out,
   output logic [31:0]             rsp_frames_dropped_now,
   output logic [SMP_W-1:0]        rsp_fill_level,
   output logic [SMP_W-1:0]        rsp_peak_level,
   output logic [SMP_W-1:0]        rsp_space_left,
   output logic [31:0]             rsp_lost_count,
   output logic [31:0]             rsp_stored_count,
   output logic [31:0]             rsp_taken_count
);

   localparam int unsigned ADDR_W = $clog2(RING_FRAMES);
   localparam int unsigned LVL_W  = ADDR_W + 1;
   localparam int unsigned PK_W   = LVL_W + 1;
   localparam int unsigned RD_W   = (READER_COUNT > 1) ? $clog2(READER_COUNT) : 1;
   localparam logic [31:0]       RING32   = 32'(RING_FRAMES);
   localparam logic [LVL_W-1:0]  RING_LVL = LVL_W'(RING_FRAMES);
   localparam logic [RD_W-1:0]   LAST_RD  = RD_W'(READER_COUNT - 1);
   localparam logic [31:0]       CH32     = 32'(CHANNELS);

   state_type  state_ff, state_in;
   action_type action_ff, action_in;
   logic [2:0]  reader_ff, reader_in;
   logic [31:0] sample_ff, sample_in;
   logic [15:0] keep_ff, keep_in;

   logic [31:0] wpos_ff, wpos_in;
   logic [31:0] written_ff, written_in;
   logic [31:0] rpos_ff    [READER_COUNT];
   logic [31:0] rpos_in    [READER_COUNT];
   logic [31:0] dropped_ff [READER_COUNT];
   logic [31:0] dropped_in [READER_COUNT];
   logic [31:0] rcount_ff  [READER_COUNT];
   logic [31:0] rcount_in  [READER_COUNT];
   logic [PK_W-1:0] peak_ff [READER_COUNT];
   logic [PK_W-1:0] peak_in [READER_COUNT];

   logic             done_ff, done_in;
   logic [31:0]      drop_now_ff, drop_now_in;
   logic [RD_W-1:0]  idx_ff, idx_in;
   logic [LVL_W-1:0] max_ff, max_in;
   logic [LVL_W-1:0] level_ff, level_in;

   logic [31:0] store_mem [RING_FRAMES];
   logic [31:0] rdata_ff;
   logic              mem_we, mem_re;
   logic [ADDR_W-1:0] mem_waddr, mem_raddr;

   logic            valid;
   logic [RD_W-1:0] sel;
   logic [31:0]     cur_rp, avail, lost, keep_c, trim;
   logic [31:0]     scan_avail;
   logic [LVL_W-1:0] scan_lvl;
   logic [PK_W-1:0]  scan_smp;

   logic [31:0] level_w, peak_w, free_w;
   logic        read_ok;

   assign valid      = {1'b0, reader_ff} < 4'(READER_COUNT);
   assign sel        = reader_ff[RD_W-1:0];
   assign cur_rp     = rpos_ff[sel];
   assign avail      = wpos_ff - cur_rp;
   assign lost       = avail - RING32;
   assign keep_c     = (32'(keep_ff) > RING32) ? RING32 : 32'(keep_ff);
   assign trim       = avail - keep_c;
   assign scan_avail = wpos_ff - rpos_ff[idx_ff];
   assign scan_lvl   = (scan_avail > RING32) ? RING_LVL : scan_avail[LVL_W-1:0];
   assign scan_smp   = PK_W'(32'(scan_lvl) * CH32);

   always_comb begin
      state_in    = state_ff;
      action_in   = action_ff;
      reader_in   = reader_ff;
      sample_in   = sample_ff;
      keep_in     = keep_ff;
      wpos_in     = wpos_ff;
      written_in  = written_ff;
      rpos_in     = rpos_ff;
      dropped_in  = dropped_ff;
      rcount_in   = rcount_ff;
      peak_in     = peak_ff;
      done_in     = done_ff;
      drop_now_in = drop_now_ff;
      idx_in      = idx_ff;
      max_in      = max_ff;
      level_in    = level_ff;
      mem_we      = 1'b0;
      mem_re      = 1'b0;
      mem_waddr   = wpos_ff[ADDR_W-1:0];
      mem_raddr   = cur_rp[ADDR_W-1:0];

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               action_in   = action_type'(req_action);
               reader_in   = req_reader;
               sample_in   = {req_right_sample, req_left_sample};
               keep_in     = req_keep_frames;
               done_in     = 1'b0;
               drop_now_in = '0;
               state_in    = ST_CATCH;
            end
         end
         ST_CATCH: begin
            if (action_ff == ACT_WRITE) begin
               mem_we     = 1'b1;
               wpos_in    = wpos_ff + 32'd1;
               written_in = written_ff + CH32;
            end else if (valid && action_ff == ACT_RESET) begin
               rpos_in[sel]    = wpos_ff;
               dropped_in[sel] = '0;
               rcount_in[sel]  = '0;
               peak_in[sel]    = '0;
            end else if (valid && avail > RING32) begin
               rpos_in[sel]    = cur_rp + lost;
               dropped_in[sel] = dropped_ff[sel] + lost * CH32;
               if (action_ff == ACT_DROP) begin
                  drop_now_in = lost;
               end
            end
            state_in = ST_ACT;
         end
         ST_ACT: begin
            unique case (action_ff)
               ACT_WRITE: begin
                  done_in = 1'b1;
               end
               ACT_READ: begin
                  if (valid && avail != '0) begin
                     mem_re         = 1'b1;
                     rpos_in[sel]   = cur_rp + 32'd1;
                     rcount_in[sel] = rcount_ff[sel] + CH32;
                     done_in        = 1'b1;
                  end
               end
               ACT_DROP: begin
                  if (valid && avail > keep_c) begin
                     rpos_in[sel]    = cur_rp + trim;
                     dropped_in[sel] = dropped_ff[sel] + trim * CH32;
                     drop_now_in     = drop_now_ff + trim;
                  end
               end
               ACT_RESET: begin
               end
               default: begin
               end
            endcase
            idx_in   = '0;
            max_in   = '0;
            level_in = '0;
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (scan_lvl > max_ff) begin
               max_in = scan_lvl;
            end
            if (idx_ff == sel) begin
               level_in = scan_lvl;
            end
            if (action_ff == ACT_WRITE && scan_smp > peak_ff[idx_ff]) begin
               peak_in[idx_ff] = scan_smp;
            end
            if (idx_ff == LAST_RD) begin
               state_in = ST_RESP;
            end else begin
               idx_in = idx_ff + RD_W'(1);
            end
         end
         ST_RESP: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         wpos_ff    <= '0;
         written_ff <= '0;
         done_ff    <= 1'b0;
         for (int i = 0; i < READER_COUNT; i++) begin
            rpos_ff[i]    <= '0;
            dropped_ff[i] <= '0;
            rcount_ff[i]  <= '0;
            peak_ff[i]    <= '0;
         end
      end else begin
         state_ff   <= state_in;
         wpos_ff    <= wpos_in;
         written_ff <= written_in;
         done_ff    <= done_in;
         rpos_ff    <= rpos_in;
         dropped_ff <= dropped_in;
         rcount_ff  <= rcount_in;
         peak_ff    <= peak_in;
      end
   end

   always_ff @(posedge clock) begin
      action_ff   <= action_in;
      reader_ff   <= reader_in;
      sample_ff   <= sample_in;
      keep_ff     <= keep_in;
      drop_now_ff <= drop_now_in;
      idx_ff      <= idx_in;
      max_ff      <= max_in;
      level_ff    <= level_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_mem[mem_waddr] <= sample_ff;
      end
      if (mem_re) begin
         rdata_ff <= store_mem[mem_raddr];
      end
   end

   assign busy    = (state_ff != ST_IDLE);
   assign read_ok = done_ff && (action_ff == ACT_READ);
   assign level_w = 32'(level_ff) * CH32;
   assign peak_w  = 32'(peak_ff[sel]);
   assign free_w  = 32'(RING_LVL - max_ff) * CH32;

   assign rsp_strobe             = (state_ff == ST_RESP);
   assign rsp_done_res           = done_ff;
   assign rsp_left_out           = read_ok ? rdata_ff[15:0] : '0;
   assign rsp_right_out          = read_ok ? rdata_ff[31:16] : '0;
   assign rsp_frames_dropped_now = (valid && action_ff == ACT_DROP) ? drop_now_ff : '0;
   assign rsp_fill_level         = valid ? level_w[SMP_W-1:0] : '0;
   assign rsp_peak_level         = valid ? peak_w[SMP_W-1:0] : '0;
   assign rsp_space_left         = free_w[SMP_W-1:0];
   assign rsp_lost_count         = valid ? dropped_ff[sel] : '0;
   assign rsp_stored_count       = written_ff;
   assign rsp_taken_count        = valid ? rcount_ff[sel] : '0;

endmodule

@@ tb/tb.sv @@
module tb
   import mrar_pkg::*;
();

   localparam int unsigned FRAMES  = RING_FRAMES_DEF;
   localparam int unsigned READERS = READER_COUNT_DEF;
   localparam int unsigned LATENCY = READERS + 4;
   localparam int unsigned ADDR_W  = $clog2(FRAMES);
   localparam int unsigned RD_W    = (READERS > 1) ? $clog2(READERS) : 1;

   typedef struct {
      logic               done;
      logic signed [15:0] left;
      logic signed [15:0] right;
      logic [31:0]        dropped_now;
      logic [SMP_W-1:0]   level;
      logic [SMP_W-1:0]   peak;
      logic [SMP_W-1:0]   free;
      logic [31:0]        dropped;
      logic [31:0]        written;
      logic [31:0]        reads;
   } ring_status_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [1:0] req_action = '0;
   logic [2:0] req_reader = '0;
   logic signed [15:0] req_left_sample = '0;
   logic signed [15:0] req_right_sample = '0;
   logic [15:0] req_keep_frames = '0;
   logic rsp_strobe;
   logic rsp_done_res;
   logic signed [15:0] rsp_left_out;
   logic signed [15:0] rsp_right_out;
   logic [31:0] rsp_frames_dropped_now;
   logic [SMP_W-1:0] rsp_fill_level;
   logic [SMP_W-1:0] rsp_peak_level;
   logic [SMP_W-1:0] rsp_space_left;
   logic [31:0] rsp_lost_count;
   logic [31:0] rsp_stored_count;
   logic [31:0] rsp_taken_count;

   // ring shadow
   logic [31:0] frame_mem [FRAMES];
   logic [31:0] wr_pos = '0;
   logic [31:0] put_total = '0;
   logic [31:0] rd_pos [READERS] = '{default: '0};
   logic [31:0] drop_total [READERS] = '{default: '0};
   logic [31:0] take_total [READERS] = '{default: '0};
   logic [31:0] peak_lvl [READERS] = '{default: '0};

   ring_status_type pending_status[$];
   int fail_count = 0;
   int words_sent = 0;
   int words_checked = 0;
   int gap_pct = 0;

   multi_reader_audio_ring_unit u_top (
      .clock                  (clock),
      .reset                  (reset),
      .start                  (start),
      .busy                   (busy),
      .req_action             (req_action),
      .req_reader             (req_reader),
      .req_left_sample        (req_left_sample),
      .req_right_sample       (req_right_sample),
      .req_keep_frames        (req_keep_frames),
      .rsp_strobe             (rsp_strobe),
      .rsp_done_res           (rsp_done_res),
      .rsp_left_out           (rsp_left_out),
      .rsp_right_out          (rsp_right_out),
      .rsp_frames_dropped_now (rsp_frames_dropped_now),
      .rsp_fill_level         (rsp_fill_level),
      .rsp_peak_level         (rsp_peak_level),
      .rsp_space_left         (rsp_space_left),
      .rsp_lost_count         (rsp_lost_count),
      .rsp_stored_count       (rsp_stored_count),
      .rsp_taken_count        (rsp_taken_count)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #3000000;
      $display("multi_reader_audio_ring_unit regression: fail");
      $finish;
   end

   function automatic logic [31:0] fill_frames(logic [RD_W-1:0] r);
      logic [31:0] lv;
      lv = wr_pos - rd_pos[r];
      return (lv > FRAMES) ? FRAMES : lv;
   endfunction

   // overrun: move a lagging reader up to the oldest surviving frame
   function automatic logic [31:0] skip_overrun(logic [RD_W-1:0] r);
      logic [31:0] behind;
      logic [31:0] lost;
      behind = wr_pos - rd_pos[r];
      lost = '0;
      if (behind > FRAMES) begin
         lost = behind - FRAMES;
         rd_pos[r] += lost;
         drop_total[r] += lost * CHANNELS;
      end
      return lost;
   endfunction

   function automatic ring_status_type predict_ring(action_type act, logic [2:0] rdr,
         logic [15:0] left, logic [15:0] right, logic [15:0] keep);
      ring_status_type s;
      logic known;
      logic [31:0] keep_c;
      logic [31:0] avail;
      logic [31:0] trim;
      logic [31:0] hi;
      logic [31:0] lv;
      logic [RD_W-1:0] r;
      logic [RD_W-1:0] k;
      int unsigned i;
      s = '{default: '0};
      r = rdr[RD_W-1:0];
      known = (rdr < READERS);
      keep_c = (keep > FRAMES) ? FRAMES : 32'(keep);
      if (act == ACT_WRITE) begin
         frame_mem[wr_pos[ADDR_W-1:0]] = {right, left};
         wr_pos += 32'd1;
         put_total += CHANNELS;
         for (i = 0; i < READERS; i++) begin
            k = RD_W'(i);
            lv = fill_frames(k) * CHANNELS;
            if (lv > peak_lvl[k]) peak_lvl[k] = lv;
         end
         s.done = 1'b1;
      end else if (known && act == ACT_READ) begin
         void'(skip_overrun(r));
         if (wr_pos != rd_pos[r]) begin
            {s.right, s.left} = frame_mem[rd_pos[r][ADDR_W-1:0]];
            rd_pos[r] += 32'd1;
            take_total[r] += CHANNELS;
            s.done = 1'b1;
         end
      end else if (known && act == ACT_DROP) begin
         s.dropped_now = skip_overrun(r);
         avail = wr_pos - rd_pos[r];
         if (avail > keep_c) begin
            trim = avail - keep_c;
            rd_pos[r] += trim;
            drop_total[r] += trim * CHANNELS;
            s.dropped_now += trim;
         end
      end else if (known && act == ACT_RESET) begin
         rd_pos[r] = wr_pos;
         drop_total[r] = '0;
         take_total[r] = '0;
         peak_lvl[r] = '0;
      end
      hi = '0;
      for (i = 0; i < READERS; i++) begin
         k = RD_W'(i);
         if (fill_frames(k) > hi) hi = fill_frames(k);
      end
      lv = (FRAMES - hi) * CHANNELS;
      s.free = lv[SMP_W-1:0];
      s.written = put_total;
      if (known) begin
         lv = fill_frames(r) * CHANNELS;
         s.level = lv[SMP_W-1:0];
         s.peak = peak_lvl[r][SMP_W-1:0];
         s.dropped = drop_total[r];
         s.reads = take_total[r];
      end
      return s;
   endfunction

   task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      ring_status_type want;
      if (!reset && rsp_strobe) begin
         if (pending_status.size() == 0) begin
            $error("result word with nothing pending");
            fail_count++;
         end else begin
            want = pending_status.pop_front();
            words_checked++;
            check_field("done_res", 32'(want.done), 32'(rsp_done_res));
            check_field("left_out", 32'(want.left), 32'(rsp_left_out));
            check_field("right_out", 32'(want.right), 32'(rsp_right_out));
            check_field("frames_dropped_now", want.dropped_now, rsp_frames_dropped_now);
            check_field("fill_level", 32'(want.level), 32'(rsp_fill_level));
            check_field("peak_level", 32'(want.peak), 32'(rsp_peak_level));
            check_field("space_left", 32'(want.free), 32'(rsp_space_left));
            check_field("lost_count", want.dropped, rsp_lost_count);
            check_field("stored_count", want.written, rsp_stored_count);
            check_field("taken_count", want.reads, rsp_taken_count);
         end
      end
   end

   task automatic send_word(action_type act, logic [2:0] rdr, logic [15:0] left,
         logic [15:0] right, logic [15:0] keep);
      start <= 1'b1;
      req_action <= act;
      req_reader <= rdr;
      req_left_sample <= left;
      req_right_sample <= right;
      req_keep_frames <= keep;
      do @(posedge clock); while (busy);
      pending_status.push_back(predict_ring(act, rdr, left, right, keep));
      words_sent++;
      if ($urandom_range(99) < gap_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, LATENCY + 2)) @(posedge clock);
      end
   endtask

   task automatic wait_idle();
      start <= 1'b0;
      while (pending_status.size() != 0) @(posedge clock);
      repeat (LATENCY + 2) @(posedge clock);
   endtask

   task automatic test_edges();
      gap_pct = 20;
      send_word(ACT_WRITE, 3'd0, 16'h8000, 16'h7FFF, 16'h0000);
      send_word(ACT_WRITE, 3'd1, 16'h7FFF, 16'h8000, 16'hFFFF);
      send_word(ACT_WRITE, 3'd7, 16'hFFFF, 16'h0000, 16'h0000);
      send_word(ACT_READ, 3'd0, 16'h0000, 16'h0000, 16'h0000);
      send_word(ACT_READ, 3'd0, 16'h0000, 16'h0000, 16'h0000);
      send_word(ACT_READ, 3'd0, 16'h0000, 16'h0000, 16'h0000);
      send_word(ACT_READ, 3'd0, 16'h0000, 16'h0000, 16'h0000);  // empty
      send_word(ACT_READ, 3'd1, 16'h0000, 16'h0000, 16'h0000);
      send_word(ACT_READ, 3'd2, 16'h0000, 16'h0000, 16'h0000);  // invalid reader
      send_word(ACT_DROP, 3'd7, 16'h0000, 16'h0000, 16'h0000);
      send_word(ACT_RESET, 3'd5, 16'h0000, 16'h0000, 16'h0000);
      send_word(ACT_DROP, 3'd1, 16'h0000, 16'h0000, 16'hFFFF);  // level under keep
      send_word(ACT_DROP, 3'd1, 16'h0000, 16'h0000, 16'h0000);
      send_word(ACT_WRITE, 3'd0, 16'h1234, 16'hEDCB, 16'h0000);
      send_word(ACT_WRITE, 3'd0, 16'h5555, 16'hAAAA, 16'h0000);
      send_word(ACT_DROP, 3'd0, 16'h0000, 16'h0000, 16'h0001);
      send_word(ACT_RESET, 3'd0, 16'h0000, 16'h0000, 16'h0000);
      send_word(ACT_RESET, 3'd1, 16'h0000, 16'h0000, 16'h0000);
      wait_idle();
   endtask

   // long write run, then trims and reads on both readers
   task automatic test_trim();
      gap_pct = 0;
      send_word(ACT_RESET, 3'd0, 16'h0000, 16'h0000, 16'h0000);
      send_word(ACT_RESET, 3'd1, 16'h0000, 16'h0000, 16'h0000);
      repeat (48) send_word(ACT_WRITE, 3'($urandom_range(7)),
            16'($urandom), 16'($urandom), 16'($urandom));
      send_word(ACT_DROP, 3'd1, 16'h0000, 16'h0000, 16'hFFFF);
      send_word(ACT_READ, 3'd0, 16'h0000, 16'h0000, 16'h0000);
      send_word(ACT_READ, 3'd1, 16'h0000, 16'h0000, 16'h0000);
      repeat (8) send_word(ACT_WRITE, 3'd0, 16'($urandom), 16'($urandom), 16'h0000);
      send_word(ACT_DROP, 3'd0, 16'h0000, 16'h0000, 16'd3);
      send_word(ACT_READ, 3'd0, 16'h0000, 16'h0000, 16'h0000);
      send_word(ACT_READ, 3'd1, 16'h0000, 16'h0000, 16'h0000);
      send_word(ACT_DROP, 3'd1, 16'h0000, 16'h0000, 16'd0);
      wait_idle();
   endtask

   task automatic random_words(int n);
      action_type act;
      logic [2:0] rdr;
      logic [15:0] keep;
      int pick;
      repeat (n) begin
         if ($urandom_range(39) == 0) begin
            repeat ($urandom_range(4, 16))
               send_word(ACT_WRITE, 3'($urandom_range(7)), 16'($urandom), 16'($urandom),
                     16'($urandom));
         end
         pick = $urandom_range(99);
         if (pick < 45) act = ACT_WRITE;
         else if (pick < 80) act = ACT_READ;
         else if (pick < 94) act = ACT_DROP;
         else act = ACT_RESET;
         if ($urandom_range(9) == 0) rdr = 3'($urandom_range(7));
         else rdr = 3'($urandom_range(READERS - 1));
         if ($urandom_range(3) == 0) keep = 16'($urandom);
         else keep = 16'($urandom_range(40));
         send_word(act, rdr, 16'($urandom), 16'($urandom), keep);
      end
   endtask

   task automatic test_random();
      gap_pct = 33;
      random_words(100);
      wait_idle();
      gap_pct = 55;
      random_words(100);
      wait_idle();
      gap_pct = 0;
      random_words(100);
      wait_idle();
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_edges();
      test_trim();
      test_random();
      $display("%0d words sent: sample extremes, invalid readers, write runs with trims, %s",
            words_sent, "random mixes");
      $display("%0d result words checked, %0d field mismatches", words_checked, fail_count);
      if (fail_count == 0) begin
         $display("multi_reader_audio_ring_unit regression: pass");
      end else begin
         $display("multi_reader_audio_ring_unit regression: fail");
      end
      $finish;
   end

endmodule
